/* design/sitlsp_pkg.sv */
// Package for the signed integer to segment plane converter.
// Holds digit codes, the segment lookup, and the stage payload types.
// No dependencies.
package sitlsp_pkg;

	localparam int unsigned NUM_DIGITS = 4;

	localparam logic [3:0] DIGIT_E     = 4'd10;
	localparam logic [3:0] DIGIT_MINUS = 4'd11;

	localparam logic signed [15:0] VALUE_MIN = -16'sd999;
	localparam logic signed [15:0] VALUE_MAX = 16'sd9999;

	typedef logic [NUM_DIGITS-1:0][3:0] digit_codes_t;
	typedef logic [NUM_DIGITS-1:0][7:0] seg_words_t;

	typedef struct packed {
		digit_codes_t code;
		logic         out_of_range;
	} digits_t;

	function automatic logic [7:0] seg_lookup(input logic [3:0] code);
		logic [7:0] seg;
		case (code)
			4'd0:        seg = ~8'b01101011;
			4'd1:        seg = ~8'b00010001;
			4'd2:        seg = ~8'b01100111;
			4'd3:        seg = ~8'b01010111;
			4'd4:        seg = ~8'b00011101;
			4'd5:        seg = ~8'b01011110;
			4'd6:        seg = ~8'b01111110;
			4'd7:        seg = ~8'b00010011;
			4'd8:        seg = ~8'b01111111;
			4'd9:        seg = ~8'b00011111;
			DIGIT_E:     seg = ~8'b01101110;
			DIGIT_MINUS: seg = ~8'b00000100;
			4'd12:       seg = ~8'b01101011;
			4'd13:       seg = ~8'b00010001;
			4'd14:       seg = ~8'b01100111;
			default:     seg = ~8'b01010111;
		endcase
		return seg;
	endfunction

endpackage

/* design/sitlsp_value_if.sv */
// Input channel carrying one signed value per transfer.
// Plain valid/ready handshake; no dependencies.
interface sitlsp_value_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

/* design/sitlsp_plane_if.sv */
// Output channel carrying four plane words and the range flag per transfer.
// Plain valid/ready handshake; no dependencies.
interface sitlsp_plane_if;
	logic       valid;
	logic       ready;
	logic [7:0] plane0_word;
	logic [7:0] plane1_word;
	logic [7:0] plane2_word;
	logic [7:0] plane3_word;
	logic       out_of_range;

	modport source (output valid, output plane0_word, output plane1_word,
		output plane2_word, output plane3_word, output out_of_range, input ready);
	modport sink   (input valid, input plane0_word, input plane1_word,
		input plane2_word, input plane3_word, input out_of_range, output ready);
endinterface

/* design/sitlsp_digits.sv */
// Decimal digit extraction with range check and minus handling.
// Uses sitlsp_pkg; divisions by constants done as reciprocal multiplies.
module sitlsp_digits
	import sitlsp_pkg::*;
(
	input  logic signed [15:0] value,
	output digits_t            digits
);

	logic        neg;
	logic        oor;
	logic [15:0] mag16;
	logic [13:0] mag;
	logic [30:0] p1;
	logic [26:0] p2;
	logic [27:0] p3;
	logic [9:0]  q1;
	logic [6:0]  q2;
	logic [3:0]  q3;
	logic [13:0] r0;
	logic [9:0]  r1;
	logic [6:0]  r2;

	always_comb begin
		neg   = value[15];
		oor   = (value < VALUE_MIN) || (value > VALUE_MAX);
		mag16 = neg ? (16'd0 - 16'(value)) : 16'(value);
		mag   = mag16[13:0];

		p1 = {17'd0, mag} * 31'd52429;
		p2 = {13'd0, mag} * 27'd5243;
		p3 = {14'd0, mag} * 28'd8389;
		q1 = p1[28:19];
		q2 = p2[25:19];
		q3 = p3[26:23];

		r0 = mag - ({4'd0, q1} * 14'd10);
		r1 = q1 - ({3'd0, q2} * 10'd10);
		r2 = q2 - ({3'd0, q3} * 7'd10);

		if (oor) begin
			digits.code[0] = DIGIT_E;
			digits.code[1] = 4'd0;
			digits.code[2] = 4'd0;
			digits.code[3] = 4'd0;
		end else begin
			digits.code[0] = r0[3:0];
			digits.code[1] = r1[3:0];
			digits.code[2] = r2[3:0];
			digits.code[3] = neg ? DIGIT_MINUS : q3;
		end
		digits.out_of_range = oor;
	end

endmodule

/* design/sitlsp_planes.sv */
// Segment lookup per digit and transpose into common-plane words.
// Uses sitlsp_pkg for the segment table and payload types.
module sitlsp_planes
	import sitlsp_pkg::*;
(
	input  digit_codes_t code,
	output seg_words_t   planes
);

	seg_words_t seg;

	always_comb begin
		for (int d = 0; d < NUM_DIGITS; d++) begin
			seg[d] = seg_lookup(code[d]);
		end
		for (int k = 0; k < NUM_DIGITS; k++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				planes[k][2*d +: 2] = seg[d][2*k +: 2];
			end
		end
	end

endmodule

/* design/signed_int_to_lcd_segment_planes.sv */
// Top level of the signed integer to segment plane converter.
// Depends on sitlsp_pkg, sitlsp_value_if, sitlsp_plane_if, sitlsp_digits, sitlsp_planes.
//
// Usage:
//   sample: one signed 16-bit value per transfer (valid/ready).
//   result: four 8-bit plane words plus the out_of_range flag per transfer.
//   Values outside -999..9999 show E,0,0,0 with out_of_range set; negative
//   values show magnitude digits with a minus in the top digit.
// Timing:
//   Two register stages: the accepted value is held in an input register,
//   digit extraction, segment lookup and transpose sit between it and the
//   result register. The result is valid once the result register has
//   captured it, and it is held there until the receiver takes it.
//   Throughput is one item per cycle, limited only by the result receiver.
// Reset:
//   arst_n clears both stage valid flags; no result is pending after reset.
// Stall:
//   When the receiver holds ready low, the result register holds and the
//   input register takes one more value only if it is empty; then
//   sample.ready drops until the result moves.
module signed_int_to_lcd_segment_planes
	import sitlsp_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	sitlsp_value_if.sink   sample,
	sitlsp_plane_if.source result
);

	logic               valid_s1;
	logic signed [15:0] value_s1;
	logic               valid_s2;
	seg_words_t         planes_s2;
	logic               oor_s2;

	digits_t    digits;
	seg_words_t planes;
	logic       adv_s2;
	logic       adv_s1;

	sitlsp_digits u_digits (
		.value  (value_s1),
		.digits (digits)
	);

	sitlsp_planes u_planes (
		.code   (digits.code),
		.planes (planes)
	);

	assign adv_s2       = !valid_s2 || result.ready;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign sample.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= sample.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sample.valid) begin
			value_s1 <= sample.value;
		end
		if (adv_s2 && valid_s1) begin
			planes_s2 <= planes;
			oor_s2    <= digits.out_of_range;
		end
	end

	assign result.valid        = valid_s2;
	assign result.plane0_word  = planes_s2[0];
	assign result.plane1_word  = planes_s2[1];
	assign result.plane2_word  = planes_s2[2];
	assign result.plane3_word  = planes_s2[3];
	assign result.out_of_range = oor_s2;

endmodule
